FILE: rtl/core/rti_pkg.sv
// ----------------------------------------------------------------------------
// rti_pkg
// Shared types, codes and helpers of the ray/triangle intersection core.
// ----------------------------------------------------------------------------
package rti_pkg;

  localparam int ACC_W  = 68;   // accumulator width
  localparam int DOT_W  = 40;   // dot product saturation width
  localparam int NUM_W  = 56;   // divider numerator width
  localparam int DEN_W  = 40;   // divider denominator width
  localparam int QUO_W  = 57;   // signed quotient width
  localparam int ONE_Q  = 65536;

  localparam int IN_DATA_W  = 296;
  localparam int OUT_DATA_W = 136;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int OUT_HIT_BIT = 0;
  localparam int OUT_REC_BIT = 1;

  localparam logic [CFG_IDX_W-1:0] REG_EPSILON = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HAS_TEX = 2'd1;

  localparam logic [2:0] KIND_POS = 3'd0;
  localparam logic [2:0] KIND_NRM = 3'd1;
  localparam logic [2:0] KIND_TAN = 3'd2;
  localparam logic [2:0] KIND_TEX = 3'd3;
  localparam logic [2:0] KIND_RAY = 3'd4;

  localparam logic [1:0] TAG_PT  = 2'd0;
  localparam logic [1:0] TAG_NRM = 2'd1;
  localparam logic [1:0] TAG_TAN = 2'd2;
  localparam logic [1:0] TAG_UV  = 2'd3;

  localparam logic [15:0] EPS_RESET = 16'd7;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MUL, ST_ACC, ST_FIN, ST_DIV, ST_SQRT, ST_NDIV_GO, ST_EMIT
  } state_t;

  typedef enum logic [3:0] {
    PH_S1, PH_DEN, PH_U, PH_S2, PH_V, PH_T, PH_PT, PH_INTV, PH_SQ, PH_NDIV, PH_UV
  } phase_t;

  typedef enum logic [2:0] {
    EM_MISS, EM_QUERY, EM_PT, EM_NRM, EM_TAN, EM_UV
  } emit_t;

  typedef struct packed {
    logic                    start;
    logic signed [NUM_W-1:0] num;
    logic signed [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [QUO_W-1:0] quo;
  } div_rsp_t;

  typedef struct packed {
    logic        start;
    logic [63:0] x;
  } sqrt_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] root;
  } sqrt_rsp_t;

  function automatic logic signed [ACC_W-1:0] sat_s(input logic signed [ACC_W-1:0] x,
                                                    input int bits);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = (ACC_W'(1) <<< (bits - 1)) - ACC_W'(1);
    lo = -hi - ACC_W'(1);
    if (x > hi) return hi;
    if (x < lo) return lo;
    return x;
  endfunction

endpackage

FILE: rtl/core/rti_div.sv
// ----------------------------------------------------------------------------
// rti_div
// Signed restoring divider, one quotient bit per cycle, truncates toward zero.
// ----------------------------------------------------------------------------
module rti_div import rti_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic             neg_r, neg_nxt;
  logic [5:0]       cnt_r, cnt_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [NUM_W-1:0] nq_r, nq_nxt;
  logic [DEN_W-1:0] dmag_r, dmag_nxt;
  logic [DEN_W:0]   rem_sh;
  logic             ge;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    nq_nxt   = nq_r;
    dmag_nxt = dmag_r;
    rem_sh   = {rem_r, nq_r[NUM_W-1]};
    ge       = rem_sh >= {1'b0, dmag_r};
    if (req_i.start) begin
      busy_nxt = 1'b1;
      neg_nxt  = req_i.num[NUM_W-1] ^ req_i.den[DEN_W-1];
      cnt_nxt  = 6'(NUM_W);
      rem_nxt  = '0;
      nq_nxt   = req_i.num[NUM_W-1] ? NUM_W'(-req_i.num) : NUM_W'(req_i.num);
      dmag_nxt = req_i.den[DEN_W-1] ? DEN_W'(-req_i.den) : DEN_W'(req_i.den);
    end else if (busy_r) begin
      rem_nxt = ge ? DEN_W'(rem_sh - {1'b0, dmag_r}) : DEN_W'(rem_sh);
      nq_nxt  = {nq_r[NUM_W-2:0], ge};
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    neg_r  <= neg_nxt;
    cnt_r  <= cnt_nxt;
    rem_r  <= rem_nxt;
    nq_r   <= nq_nxt;
    dmag_r <= dmag_nxt;
  end

  assign rsp_o.done = done_r;
  assign rsp_o.quo  = neg_r ? -$signed({1'b0, nq_r}) : $signed({1'b0, nq_r});

endmodule

FILE: rtl/core/rti_sqrt.sv
// ----------------------------------------------------------------------------
// rti_sqrt
// Integer square root of a 64-bit value, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module rti_sqrt import rti_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  sqrt_req_t req_i,
  output sqrt_rsp_t rsp_o
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [63:0] x_r, x_nxt;
  logic [33:0] rem_r, rem_nxt;
  logic [31:0] root_r, root_nxt;
  logic [35:0] rem_sh;
  logic [35:0] trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    x_nxt    = x_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    rem_sh   = {rem_r, x_r[63:62]};
    trial    = {2'b00, root_r, 2'b01};
    if (req_i.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 6'd32;
      x_nxt    = req_i.x;
      rem_nxt  = '0;
      root_nxt = '0;
    end else if (busy_r) begin
      x_nxt = {x_r[61:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_nxt  = 34'(rem_sh - trial);
        root_nxt = {root_r[30:0], 1'b1};
      end else begin
        rem_nxt  = 34'(rem_sh);
        root_nxt = {root_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    x_r    <= x_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign rsp_o.done = done_r;
  assign rsp_o.root = root_r;

endmodule

FILE: rtl/core/ray_triangle_intersect_core.sv
// ----------------------------------------------------------------------------
// ray_triangle_intersect_core
// Moller-Trumbore ray/triangle test in Q16.16 with hit record generation.
// ----------------------------------------------------------------------------
// Load beats (position, normal, tangent, texcoord) are written to the triangle
// store when accepted. A ray beat is worked by one 32x32 multiplier with a
// 68-bit accumulator under a small sequencer, a 56-step divider and a 32-step
// square root; in_tready is low until the last result has been handed to the
// output register, and an output stall holds the sequencer. A full hit record
// has four beats (point, normal, tangent, texcoord). The divider serves u, v
// and t in turn, and each component of the two normalizations.
module ray_triangle_intersect_core import rti_pkg::*; #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // {pad, query_only, best_t, t_max, t_min, dir_z, dir_y, dir_x, pos_z, pos_y,
  //  pos_x, vertex_slot} from bit 0 up: slot[1:0], pos_x[33:2] ... query[290]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // kind
  input  logic [2:0]            in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // hit[0], record_written[1], val_x[33:2], val_y[65:34], val_z[97:66],
  // dist_t[129:98], zero pad
  output logic [OUT_DATA_W-1:0] out_tdata,
  // item_tag
  output logic [1:0]            out_tuser,
  output logic                  out_tlast,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SAT_BITS = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;

  // input fields
  logic [1:0]         in_slot;
  logic signed [31:0] in_pos [3];
  logic signed [31:0] in_dir [3];
  logic signed [31:0] in_tmin, in_tmax, in_best;
  logic               in_query;

  assign in_slot   = in_tdata[1:0];
  assign in_pos[0] = in_tdata[33:2];
  assign in_pos[1] = in_tdata[65:34];
  assign in_pos[2] = in_tdata[97:66];
  assign in_dir[0] = in_tdata[129:98];
  assign in_dir[1] = in_tdata[161:130];
  assign in_dir[2] = in_tdata[193:162];
  assign in_tmin   = in_tdata[225:194];
  assign in_tmax   = in_tdata[257:226];
  assign in_best   = in_tdata[289:258];
  assign in_query  = in_tdata[290];

  // triangle store
  logic signed [31:0] pos_r [9];
  logic signed [31:0] nrm_r [9];
  logic signed [31:0] tan_r [9];
  logic signed [31:0] tc_r  [6];

  logic [15:0] eps_r;
  logic        htex_r;

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;
  emit_t  em_r, em_nxt;
  logic [1:0] comp_r, comp_nxt;
  logic [1:0] term_r, term_nxt;
  logic       vsel_r, vsel_nxt;

  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic signed [63:0]      prod_r, prod_nxt;

  logic signed [31:0] org_r [3], org_nxt [3];
  logic signed [31:0] dir_r [3], dir_nxt [3];
  logic signed [31:0] e1_r  [3], e1_nxt  [3];
  logic signed [31:0] e2_r  [3], e2_nxt  [3];
  logic signed [31:0] dv_r  [3], dv_nxt  [3];
  logic signed [31:0] s1_r  [3], s1_nxt  [3];
  logic signed [31:0] s2_r  [3], s2_nxt  [3];
  logic signed [31:0] r_r   [3], r_nxt   [3];
  logic signed [31:0] tmin_r, tmin_nxt, tmax_r, tmax_nxt, best_r, best_nxt;
  logic               qonly_r, qonly_nxt;
  logic signed [DOT_W-1:0] den_r, den_nxt;
  logic signed [31:0] u_r, u_nxt, v_r, v_nxt, t_r, t_nxt, w_r, w_nxt;
  logic [31:0]        len_r, len_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic [1:0]            out_user_r, out_user_nxt;
  logic                  out_last_r, out_last_nxt;

  div_req_t  div_req;
  div_rsp_t  div_rsp;
  sqrt_req_t sq_req;
  sqrt_rsp_t sq_rsp;

  rti_div u_div (.clk(clk), .rst_n(rst_n), .req_i(div_req), .rsp_o(div_rsp));
  rti_sqrt u_sqrt (.clk(clk), .rst_n(rst_n), .req_i(sq_req), .rsp_o(sq_rsp));

  logic in_acc, cfg_acc;
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;

  // operand select and datapath
  logic [1:0]              c1, c2, ia, ib;
  logic [3:0]              xi;
  logic [2:0]              ti;
  logic signed [31:0]      op_a, op_b, wuv;
  logic                    shift_en, neg_en;
  logic [1:0]              last_term;
  logic signed [ACC_W-1:0] init_v, term_v;
  logic signed [ACC_W-1:0] sat_sh, sat_acc, sat_dot, sat_quo;
  logic signed [DOT_W-1:0] den_mag;
  logic signed [31:0]      quo32;
  logic signed [33:0]      q34, u34, eps34, lim34, uv34;
  logic                    out_ld, t_pos, q_hit;
  logic signed [31:0]      vz;

  always_comb begin
    c1 = (comp_r == 2'd2) ? 2'd0 : comp_r + 2'd1;
    c2 = (comp_r == 2'd0) ? 2'd2 : comp_r - 2'd1;
    ia = (term_r == 2'd0) ? c1 : c2;
    ib = (term_r == 2'd0) ? c2 : c1;
    xi = 4'(term_r) * 4'd3 + 4'(comp_r);
    ti = {term_r, comp_r[0]};
    case (term_r)
      2'd0:    wuv = w_r;
      2'd1:    wuv = u_r;
      default: wuv = v_r;
    endcase
    op_a      = '0;
    op_b      = '0;
    shift_en  = 1'b1;
    neg_en    = 1'b0;
    last_term = 2'd2;
    case (phase_r)
      PH_S1: begin
        op_a = dir_r[ia];
        op_b = e2_r[ib];
        shift_en = 1'b0;
        neg_en = (term_r == 2'd1);
        last_term = 2'd1;
      end
      PH_S2: begin
        op_a = dv_r[ia];
        op_b = e1_r[ib];
        shift_en = 1'b0;
        neg_en = (term_r == 2'd1);
        last_term = 2'd1;
      end
      PH_DEN: begin
        op_a = s1_r[term_r];
        op_b = e1_r[term_r];
      end
      PH_U: begin
        op_a = dv_r[term_r];
        op_b = s1_r[term_r];
      end
      PH_V: begin
        op_a = dir_r[term_r];
        op_b = s2_r[term_r];
      end
      PH_T: begin
        op_a = e2_r[term_r];
        op_b = s2_r[term_r];
      end
      PH_PT: begin
        op_a = t_r;
        op_b = dir_r[comp_r];
        last_term = 2'd0;
      end
      PH_INTV: begin
        op_a = wuv;
        op_b = vsel_r ? tan_r[xi] : nrm_r[xi];
      end
      PH_SQ: begin
        op_a = r_r[term_r];
        op_b = r_r[term_r];
        shift_en = 1'b0;
      end
      PH_UV: begin
        op_a = wuv;
        op_b = tc_r[ti];
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
    init_v  = (phase_r == PH_PT) ? ACC_W'(org_r[comp_r]) : '0;
    term_v  = shift_en ? ACC_W'(prod_r >>> 16) : ACC_W'(prod_r);
    sat_sh  = sat_s(acc_r >>> 16, SAT_BITS);
    sat_acc = sat_s(acc_r, SAT_BITS);
    sat_dot = sat_s(acc_r, DOT_W);
    sat_quo = sat_s(ACC_W'(div_rsp.quo), SAT_BITS);
    den_mag = sat_dot[DOT_W-1] ? -sat_dot[DOT_W-1:0] : sat_dot[DOT_W-1:0];
    quo32   = sat_quo[31:0];
    q34     = 34'(quo32);
    u34     = 34'(u_r);
    eps34   = {18'd0, eps_r};
    lim34   = 34'(ONE_Q) + eps34;
    uv34    = u34 + q34;
    t_pos   = t_r > 32'sd0;
    q_hit   = (tmin_r < t_r) && (t_r < tmax_r);
    out_ld  = !out_valid_r || out_tready;
  end

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    em_nxt    = em_r;
    comp_nxt  = comp_r;
    term_nxt  = term_r;
    vsel_nxt  = vsel_r;
    acc_nxt   = acc_r;
    prod_nxt  = prod_r;
    org_nxt   = org_r;
    dir_nxt   = dir_r;
    e1_nxt    = e1_r;
    e2_nxt    = e2_r;
    dv_nxt    = dv_r;
    s1_nxt    = s1_r;
    s2_nxt    = s2_r;
    r_nxt     = r_r;
    tmin_nxt  = tmin_r;
    tmax_nxt  = tmax_r;
    best_nxt  = best_r;
    qonly_nxt = qonly_r;
    den_nxt   = den_r;
    u_nxt     = u_r;
    v_nxt     = v_r;
    t_nxt     = t_r;
    w_nxt     = w_r;
    len_nxt   = len_r;
    div_req   = '0;
    sq_req    = '0;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    out_last_nxt  = out_last_r;
    vz = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_tuser == KIND_RAY) begin
          for (int i = 0; i < 3; i++) begin
            org_nxt[i] = in_pos[i];
            dir_nxt[i] = in_dir[i];
            e1_nxt[i] = 32'(sat_s(ACC_W'(pos_r[3+i]) - ACC_W'(pos_r[i]), SAT_BITS));
            e2_nxt[i] = 32'(sat_s(ACC_W'(pos_r[6+i]) - ACC_W'(pos_r[i]), SAT_BITS));
            dv_nxt[i] = 32'(sat_s(ACC_W'(in_pos[i]) - ACC_W'(pos_r[i]), SAT_BITS));
          end
          tmin_nxt  = in_tmin;
          tmax_nxt  = in_tmax;
          best_nxt  = in_best;
          qonly_nxt = in_query;
          phase_nxt = PH_S1;
          comp_nxt  = 2'd0;
          term_nxt  = 2'd0;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_nxt  = op_a * op_b;
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        acc_nxt = ((term_r == 2'd0) ? init_v : acc_r) + (neg_en ? -term_v : term_v);
        if (term_r == last_term) begin
          state_nxt = ST_FIN;
        end else begin
          term_nxt  = term_r + 2'd1;
          state_nxt = ST_MUL;
        end
      end
      ST_FIN: begin
        term_nxt  = 2'd0;
        state_nxt = ST_MUL;
        case (phase_r)
          PH_S1, PH_S2: begin
            if (phase_r == PH_S1) s1_nxt[comp_r] = sat_sh[31:0];
            else                  s2_nxt[comp_r] = sat_sh[31:0];
            if (comp_r == 2'd2) begin
              comp_nxt  = 2'd0;
              phase_nxt = (phase_r == PH_S1) ? PH_DEN : PH_V;
            end else begin
              comp_nxt = comp_r + 2'd1;
            end
          end
          PH_DEN: begin
            den_nxt = sat_dot[DOT_W-1:0];
            if (sat_dot == '0 || den_mag < DOT_W'(eps_r)) begin
              em_nxt    = EM_MISS;
              state_nxt = ST_EMIT;
            end else begin
              phase_nxt = PH_U;
            end
          end
          PH_U, PH_V, PH_T: begin
            div_req.start = 1'b1;
            div_req.num   = {sat_dot[DOT_W-1:0], 16'd0};
            div_req.den   = den_r;
            state_nxt     = ST_DIV;
          end
          PH_PT: begin
            r_nxt[comp_r] = sat_acc[31:0];
            if (comp_r == 2'd2) begin
              em_nxt    = EM_PT;
              state_nxt = ST_EMIT;
            end else begin
              comp_nxt = comp_r + 2'd1;
            end
          end
          PH_INTV: begin
            r_nxt[comp_r] = sat_acc[31:0];
            if (comp_r == 2'd2) begin
              comp_nxt  = 2'd0;
              phase_nxt = PH_SQ;
            end else begin
              comp_nxt = comp_r + 2'd1;
            end
          end
          PH_SQ: begin
            sq_req.start = 1'b1;
            sq_req.x     = acc_r[63:0];
            state_nxt    = ST_SQRT;
          end
          PH_UV: begin
            r_nxt[comp_r] = sat_acc[31:0];
            if (comp_r == 2'd1) begin
              em_nxt    = EM_UV;
              state_nxt = ST_EMIT;
            end else begin
              comp_nxt = 2'd1;
            end
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          term_nxt  = 2'd0;
          comp_nxt  = 2'd0;
          state_nxt = ST_MUL;
          case (phase_r)
            PH_U: begin
              u_nxt = quo32;
              if (q34 < -eps34 || q34 > lim34) begin
                em_nxt    = EM_MISS;
                state_nxt = ST_EMIT;
              end else begin
                phase_nxt = PH_S2;
              end
            end
            PH_V: begin
              v_nxt = quo32;
              if (q34 < -eps34 || uv34 > lim34) begin
                em_nxt    = EM_MISS;
                state_nxt = ST_EMIT;
              end else begin
                phase_nxt = PH_T;
              end
            end
            PH_T: begin
              t_nxt = quo32;
              w_nxt = 32'(sat_s(ACC_W'(ONE_Q) - ACC_W'(u_r) - ACC_W'(v_r), SAT_BITS));
              if (quo32 < tmin_r || quo32 > tmax_r) begin
                em_nxt    = EM_MISS;
                state_nxt = ST_EMIT;
              end else if (qonly_r) begin
                em_nxt    = EM_QUERY;
                state_nxt = ST_EMIT;
              end else if (quo32 > best_r) begin
                em_nxt    = EM_MISS;
                state_nxt = ST_EMIT;
              end else begin
                phase_nxt = PH_PT;
              end
            end
            PH_NDIV: begin
              r_nxt[comp_r] = quo32;
              if (comp_r == 2'd2) begin
                em_nxt    = vsel_r ? EM_TAN : EM_NRM;
                state_nxt = ST_EMIT;
              end else begin
                comp_nxt  = comp_r + 2'd1;
                state_nxt = ST_NDIV_GO;
              end
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_SQRT: begin
        if (sq_rsp.done) begin
          len_nxt  = sq_rsp.root;
          comp_nxt = 2'd0;
          if (sq_rsp.root == '0) begin
            for (int i = 0; i < 3; i++) r_nxt[i] = '0;
            em_nxt    = vsel_r ? EM_TAN : EM_NRM;
            state_nxt = ST_EMIT;
          end else begin
            phase_nxt = PH_NDIV;
            state_nxt = ST_NDIV_GO;
          end
        end
      end
      ST_NDIV_GO: begin
        div_req.start = 1'b1;
        div_req.num   = NUM_W'(r_r[comp_r]) <<< 16;
        div_req.den   = $signed({8'd0, len_r});
        state_nxt     = ST_DIV;
      end
      ST_EMIT: begin
        if (out_ld) begin
          out_valid_nxt = 1'b1;
          vz            = (em_r == EM_UV) ? 32'sd0 : r_r[2];
          out_data_nxt  = '0;
          out_user_nxt  = TAG_PT;
          out_last_nxt  = 1'b1;
          term_nxt      = 2'd0;
          comp_nxt      = 2'd0;
          state_nxt     = ST_IDLE;
          case (em_r)
            EM_MISS: begin
              out_data_nxt = '0;
            end
            EM_QUERY: begin
              out_data_nxt[OUT_HIT_BIT] = q_hit;
              out_data_nxt[129:98]      = t_r;
            end
            EM_PT, EM_NRM, EM_TAN, EM_UV: begin
              out_data_nxt = {6'd0, t_r, vz, r_r[1], r_r[0], 1'b1, t_pos};
              out_last_nxt = (em_r == EM_UV);
              case (em_r)
                EM_PT: begin
                  out_user_nxt = TAG_PT;
                  phase_nxt    = PH_INTV;
                  vsel_nxt     = 1'b0;
                  state_nxt    = ST_MUL;
                end
                EM_NRM: begin
                  out_user_nxt = TAG_NRM;
                  phase_nxt    = PH_INTV;
                  vsel_nxt     = 1'b1;
                  state_nxt    = ST_MUL;
                end
                EM_TAN: begin
                  out_user_nxt = TAG_TAN;
                  if (htex_r) begin
                    phase_nxt = PH_UV;
                    state_nxt = ST_MUL;
                  end else begin
                    for (int i = 0; i < 3; i++) r_nxt[i] = '0;
                    em_nxt    = EM_UV;
                    state_nxt = ST_EMIT;
                  end
                end
                default: begin
                  out_user_nxt = TAG_UV;
                end
              endcase
            end
            default: begin
              out_data_nxt = '0;
            end
          endcase
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // triangle store and configuration
  always_ff @(posedge clk) begin
    if (in_acc && in_slot != 2'd3) begin
      case (in_tuser)
        KIND_POS: for (int i = 0; i < 3; i++) pos_r[in_slot*3+i] <= in_pos[i];
        KIND_NRM: for (int i = 0; i < 3; i++) nrm_r[in_slot*3+i] <= in_pos[i];
        KIND_TAN: for (int i = 0; i < 3; i++) tan_r[in_slot*3+i] <= in_pos[i];
        KIND_TEX: begin
          tc_r[{in_slot, 1'b0}] <= in_pos[0];
          tc_r[{in_slot, 1'b1}] <= in_pos[1];
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r  <= EPS_RESET;
      htex_r <= 1'b0;
    end else if (cfg_acc) begin
      case (cfg_index)
        REG_EPSILON: eps_r  <= cfg_data;
        REG_HAS_TEX: htex_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    phase_r    <= phase_nxt;
    em_r       <= em_nxt;
    comp_r     <= comp_nxt;
    term_r     <= term_nxt;
    vsel_r     <= vsel_nxt;
    acc_r      <= acc_nxt;
    prod_r     <= prod_nxt;
    org_r      <= org_nxt;
    dir_r      <= dir_nxt;
    e1_r       <= e1_nxt;
    e2_r       <= e2_nxt;
    dv_r       <= dv_nxt;
    s1_r       <= s1_nxt;
    s2_r       <= s2_nxt;
    r_r        <= r_nxt;
    tmin_r     <= tmin_nxt;
    tmax_r     <= tmax_nxt;
    best_r     <= best_nxt;
    qonly_r    <= qonly_nxt;
    den_r      <= den_nxt;
    u_r        <= u_nxt;
    v_r        <= v_nxt;
    t_r        <= t_nxt;
    w_r        <= w_nxt;
    len_r      <= len_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule

FILE: rtl/core/rti_checker.sv
// ----------------------------------------------------------------------------
// rti_checker
// Port-level checks of the ray/triangle intersection core.
// ----------------------------------------------------------------------------
module rti_checker import rti_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [2:0]            in_tuser,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [1:0]            out_tuser,
  input logic                  out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast))
    else $error("result beat changed while stalled");

  a_nonlast_is_record: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tdata[OUT_REC_BIT] && out_tuser != TAG_UV)
    else $error("non-final beat outside a hit record");

  a_record_ends_uv: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast && out_tdata[OUT_REC_BIT] |-> out_tuser == TAG_UV)
    else $error("hit record not closed by uv beat");

  a_ray_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == KIND_RAY |=> !in_tready)
    else $error("ready after ray beat");

endmodule

bind ray_triangle_intersect_core rti_checker u_rti_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .in_tuser(in_tuser), .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tlast(out_tlast)
);
